FILE: sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cell writer: field widths,
// action and sweep codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

	localparam int ACTION_W   = 3;
	localparam int CHAR_W     = 8;
	localparam int ROW_SEL_W  = 5;
	localparam int COL_SEL_W  = 7;
	localparam int CELL_W     = 16;
	localparam int COLOUR_W   = 8;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [CHAR_W-1:0]   CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0]   CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0]   CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0]   CH_BLANK = 8'h20;

	localparam logic [COLOUR_W-1:0] TEXT_COLOUR_RST   = 8'h0F;
	localparam logic [COLOUR_W-1:0] STATUS_COLOUR_RST = 8'h1F;
	localparam logic [CELL_W-1:0]   RESET_CELL        = {TEXT_COLOUR_RST, CH_BLANK};

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUT       = 3'd0,
		ACT_CLEAR     = 3'd1,
		ACT_CLEAR_ROW = 3'd2,
		ACT_WRITE_AT  = 3'd3,
		ACT_READ      = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		SW_RESET_FILL,
		SW_CLEAR_ALL,
		SW_CLEAR_ROW,
		SW_SCROLL_COPY,
		SW_SCROLL_BLANK
	} sweep_kind_t;

	typedef enum logic [2:0] {
		NX_DONE,
		NX_READ,
		NX_SCROLL,
		NX_CLEAR_ALL,
		NX_CLEAR_ROW
	} exec_next_t;

	typedef enum logic [2:0] {
		ST_BOOT,
		ST_BOOT_FILL,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        load_item;
		logic        exec;
		logic        capture_cell;
		logic        sweep_start;
		sweep_kind_t sweep_kind;
		logic        sweep_step;
		logic        emit;
	} cmd_t;

	typedef struct packed {
		exec_next_t exec_next;
		logic       sweep_last;
	} status_t;

endpackage

`default_nettype wire

FILE: sv/text_console_cell_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text-mode console engine: a screen of colour/character cells with a status
// row, a cursor, and put-char, clear, clear-row, write-at and read-cell.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid / in_stall     action, char_code, row_sel, col_sel
//   out      from block out_valid / out_stall   cell_value, cursor_row_now,
//                                               cursor_col_now
//   config   to block   APB psel/penable/pready text_colour @0, status_colour @4
//
// Put char, write at and the actions that change nothing go through the execute and
// done states; read cell adds a state for the registered read of the screen memory.
// Clear row, clear screen and a scroll sweep COLUMNS, ROWS*COLUMNS and
// (ROWS-1)*COLUMNS cells: the single memory write port moves one cell a cycle.
// After reset a clearing pass blanks the screen while in_stall stays high;
// configuration writes are taken throughout.
// A finished result waits in the output register while the next request is
// taken; a stalled output holds the block only once a further result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tccw_pkg::APB_AW-1:0]    paddr,
	input  wire logic [tccw_pkg::APB_DW-1:0]    pwdata,
	output logic      [tccw_pkg::APB_DW-1:0]    prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [tccw_pkg::ACTION_W-1:0]  action,
	input  wire logic [tccw_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [tccw_pkg::ROW_SEL_W-1:0] row_sel,
	input  wire logic [tccw_pkg::COL_SEL_W-1:0] col_sel,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [tccw_pkg::CELL_W-1:0]    cell_value,
	output logic      [tccw_pkg::ROW_SEL_W-1:0] cursor_row_now,
	output logic      [tccw_pkg::COL_SEL_W-1:0] cursor_col_now
);
	import tccw_pkg::*;

	logic [COLOUR_W-1:0] text_colour;
	logic [COLOUR_W-1:0] status_colour;
	cmd_t                cmd;
	status_t             st;

	tccw_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.text_colour   (text_colour),
		.status_colour (status_colour)
	);

	tccw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	tccw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.text_colour    (text_colour),
		.status_colour  (status_colour),
		.action         (action),
		.char_code      (char_code),
		.row_sel        (row_sel),
		.col_sel        (col_sel),
		.cell_value     (cell_value),
		.cursor_row_now (cursor_row_now),
		.cursor_col_now (cursor_col_now)
	);

endmodule

`default_nettype wire

FILE: sv/tccw_regs.sv
// ----------------------------------------------------------------------------
// tccw_regs
// Configuration registers behind the APB port: text and status colours.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tccw_pkg::APB_AW-1:0]   paddr,
	input  wire logic [tccw_pkg::APB_DW-1:0]   pwdata,
	output logic      [tccw_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output logic      [tccw_pkg::COLOUR_W-1:0] text_colour,
	output logic      [tccw_pkg::COLOUR_W-1:0] status_colour
);
	import tccw_pkg::*;

	localparam logic REG_TEXT_COLOUR   = 1'b0;
	localparam logic REG_STATUS_COLOUR = 1'b1;

	logic                wr_en;
	logic                reg_idx;
	logic [COLOUR_W-1:0] text_colour_q;
	logic [COLOUR_W-1:0] status_colour_q;

	// Registers sit at byte addresses 0 and 4, so bit 2 picks one.
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_colour_q   <= TEXT_COLOUR_RST;
			status_colour_q <= STATUS_COLOUR_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TEXT_COLOUR:   text_colour_q   <= pwdata[COLOUR_W-1:0];
				REG_STATUS_COLOUR: status_colour_q <= pwdata[COLOUR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_TEXT_COLOUR:   prdata = APB_DW'(text_colour_q);
			REG_STATUS_COLOUR: prdata = APB_DW'(status_colour_q);
			default: ;
		endcase
	end

	assign text_colour   = text_colour_q;
	assign status_colour = status_colour_q;

endmodule

`default_nettype wire

FILE: sv/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl
// Controller of the console: sequences the reset clear, one request's
// execution, memory sweeps for clears and scrolling, and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire tccw_pkg::status_t st,
	output tccw_pkg::cmd_t         cmd
);
	import tccw_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_BOOT: begin
				cmd.sweep_start = 1'b1;
				cmd.sweep_kind  = SW_RESET_FILL;
				state_d         = ST_BOOT_FILL;
			end
			ST_BOOT_FILL: begin
				cmd.sweep_step = 1'b1;
				if (st.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				unique case (st.exec_next)
					NX_DONE: state_d = ST_DONE;
					NX_READ: state_d = ST_READ;
					NX_SCROLL: begin
						cmd.sweep_start = 1'b1;
						cmd.sweep_kind  = SW_SCROLL_COPY;
						state_d         = ST_COPY;
					end
					NX_CLEAR_ALL: begin
						cmd.sweep_start = 1'b1;
						cmd.sweep_kind  = SW_CLEAR_ALL;
						state_d         = ST_FILL;
					end
					NX_CLEAR_ROW: begin
						cmd.sweep_start = 1'b1;
						cmd.sweep_kind  = SW_CLEAR_ROW;
						state_d         = ST_FILL;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_READ: begin
				cmd.capture_cell = 1'b1;
				state_d          = ST_DONE;
			end
			ST_COPY: begin
				cmd.sweep_step = 1'b1;
				// The blanking of the last text row follows the copy directly.
				if (st.sweep_last) begin
					cmd.sweep_start = 1'b1;
					cmd.sweep_kind  = SW_SCROLL_BLANK;
					state_d         = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.sweep_step = 1'b1;
				if (st.sweep_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					in_stall = 1'b0;
					if (in_valid) begin
						cmd.load_item = 1'b1;
						state_d       = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_BOOT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EXEC))
		else $error("accepted request did not enter execution");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL || state_q == ST_COPY || state_q == ST_BOOT_FILL)
		|-> (in_stall && !cmd.emit))
		else $error("request taken or result given during a memory sweep");

endmodule

`default_nettype wire

FILE: sv/tccw_dp.sv
// ----------------------------------------------------------------------------
// tccw_dp
// Datapath of the console: screen memory, cursor, request register, the
// action decode, the sweep address engine and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_dp #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tccw_pkg::cmd_t                 cmd,
	output tccw_pkg::status_t                   st,
	input  wire logic [tccw_pkg::COLOUR_W-1:0]  text_colour,
	input  wire logic [tccw_pkg::COLOUR_W-1:0]  status_colour,
	input  wire logic [tccw_pkg::ACTION_W-1:0]  action,
	input  wire logic [tccw_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [tccw_pkg::ROW_SEL_W-1:0] row_sel,
	input  wire logic [tccw_pkg::COL_SEL_W-1:0] col_sel,
	output logic      [tccw_pkg::CELL_W-1:0]    cell_value,
	output logic      [tccw_pkg::ROW_SEL_W-1:0] cursor_row_now,
	output logic      [tccw_pkg::COL_SEL_W-1:0] cursor_col_now
);
	import tccw_pkg::*;

	localparam int NCELLS = ROWS * COLUMNS;
	localparam int AW     = $clog2(NCELLS);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLUMNS);

	localparam logic [RW-1:0] LAST_TEXT_ROW = RW'(ROWS - 2);
	localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);
	localparam logic [AW-1:0] LAST_CELL     = AW'(NCELLS - 1);
	localparam logic [AW-1:0] COPY_LAST     = AW'((ROWS - 2) * COLUMNS - 1);
	localparam logic [AW-1:0] BLANK_FIRST   = AW'((ROWS - 2) * COLUMNS);
	localparam logic [AW-1:0] BLANK_LAST    = AW'((ROWS - 1) * COLUMNS - 1);
	localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);

	logic [CELL_W-1:0] mem [NCELLS];

	// Request register
	logic [ACTION_W-1:0]  action_q;
	logic [CHAR_W-1:0]    char_q;
	logic [ROW_SEL_W-1:0] row_q;
	logic [COL_SEL_W-1:0] col_q;

	logic [RW-1:0]     cur_row_q;
	logic [CW-1:0]     cur_col_q;
	logic [CELL_W-1:0] cell_q;
	logic [CELL_W-1:0] rdata_q;

	// Sweep engine
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     last_q;
	logic [CELL_W-1:0] fill_q;
	logic              copy_q;

	// Write stage: every memory write goes through here.
	logic              we_s1;
	logic [AW-1:0]     waddr_s1;
	logic [CELL_W-1:0] wdata_s1;
	logic              wcopy_s1;

	logic [CELL_W-1:0]    cell_value_q;
	logic [ROW_SEL_W-1:0] cursor_row_now_q;
	logic [COL_SEL_W-1:0] cursor_col_now_q;

	logic                row_ok;
	logic                col_ok;
	logic                on_status_row;
	logic [COLOUR_W-1:0] row_colour;
	logic [AW-1:0]       item_base;
	logic [AW-1:0]       item_addr;
	logic [AW-1:0]       cur_addr;
	logic [AW-1:0]       rd_addr;

	exec_next_t        ex_next;
	logic              ex_we;
	logic [AW-1:0]     ex_waddr;
	logic [CELL_W-1:0] ex_wdata;
	logic [RW-1:0]     ex_row;
	logic [CW-1:0]     ex_col;

	assign row_ok        = 32'(row_q) < ROWS;
	assign col_ok        = 32'(col_q) < COLUMNS;
	assign on_status_row = 32'(row_q) == ROWS - 1;
	assign row_colour    = on_status_row ? status_colour : text_colour;
	assign item_base     = AW'(AW'(row_q) * COLS_A);
	assign item_addr     = AW'(item_base + AW'(col_q));
	assign cur_addr      = AW'(AW'(AW'(cur_row_q) * COLS_A) + AW'(cur_col_q));

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= action;
			char_q   <= char_code;
			row_q    <= row_sel;
			col_q    <= col_sel;
		end
	end

	// Decode of one request against the current cursor.
	always_comb begin
		ex_next  = NX_DONE;
		ex_we    = 1'b0;
		ex_waddr = cur_addr;
		ex_wdata = {text_colour, char_q};
		ex_row   = cur_row_q;
		ex_col   = cur_col_q;
		case (action_q)
			ACT_PUT: begin
				if (char_q == CH_CR) begin
					ex_col = '0;
				end else if (char_q == CH_BS) begin
					// One cell back is always the linear address minus one.
					if (cur_col_q != '0 || cur_row_q != '0) begin
						ex_we    = 1'b1;
						ex_waddr = AW'(cur_addr - 1'b1);
						ex_wdata = {text_colour, CH_BLANK};
						if (cur_col_q != '0) begin
							ex_col = CW'(cur_col_q - 1'b1);
						end else begin
							ex_row = RW'(cur_row_q - 1'b1);
							ex_col = LAST_COL;
						end
					end
				end else begin
					if (char_q != CH_LF) begin
						ex_we = 1'b1;
					end
					if (char_q == CH_LF || cur_col_q == LAST_COL) begin
						ex_col = '0;
						if (cur_row_q == LAST_TEXT_ROW) begin
							ex_next = NX_SCROLL;
						end else begin
							ex_row = RW'(cur_row_q + 1'b1);
						end
					end else begin
						ex_col = CW'(cur_col_q + 1'b1);
					end
				end
			end
			ACT_CLEAR: begin
				ex_next = NX_CLEAR_ALL;
				ex_row  = '0;
				ex_col  = '0;
			end
			ACT_CLEAR_ROW: begin
				if (row_ok) begin
					ex_next = NX_CLEAR_ROW;
				end
			end
			ACT_WRITE_AT: begin
				ex_waddr = item_addr;
				ex_wdata = {row_colour, char_q};
				ex_we    = row_ok && col_ok;
			end
			ACT_READ: begin
				if (row_ok && col_ok) begin
					ex_next = NX_READ;
				end
			end
			default: ;
		endcase
	end

	assign st.exec_next  = ex_next;
	assign st.sweep_last = (ptr_q == last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else if (cmd.exec) begin
			cur_row_q <= ex_row;
			cur_col_q <= ex_col;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_start) begin
			copy_q <= 1'b0;
			case (cmd.sweep_kind)
				SW_RESET_FILL: begin
					ptr_q  <= '0;
					last_q <= LAST_CELL;
					fill_q <= RESET_CELL;
				end
				SW_CLEAR_ALL: begin
					ptr_q  <= '0;
					last_q <= LAST_CELL;
					fill_q <= {text_colour, CH_BLANK};
				end
				SW_CLEAR_ROW: begin
					ptr_q  <= item_base;
					last_q <= AW'(item_base + AW'(COLUMNS - 1));
					fill_q <= {row_colour, CH_BLANK};
				end
				SW_SCROLL_COPY: begin
					ptr_q  <= '0;
					last_q <= COPY_LAST;
					copy_q <= 1'b1;
				end
				SW_SCROLL_BLANK: begin
					ptr_q  <= BLANK_FIRST;
					last_q <= BLANK_LAST;
					fill_q <= {text_colour, CH_BLANK};
				end
				default: ;
			endcase
		end else if (cmd.sweep_step) begin
			ptr_q <= AW'(ptr_q + 1'b1);
		end
	end

	// A copy reads one row below the destination.
	assign rd_addr = (cmd.sweep_step && copy_q) ? AW'(ptr_q + COLS_A) : item_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
		end else begin
			we_s1 <= cmd.sweep_step || (cmd.exec && ex_we);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			waddr_s1 <= ptr_q;
			wdata_s1 <= fill_q;
			wcopy_s1 <= copy_q;
		end else begin
			waddr_s1 <= ex_waddr;
			wdata_s1 <= ex_wdata;
			wcopy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we_s1) begin
			mem[waddr_s1] <= wcopy_s1 ? rdata_q : wdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			cell_q <= '0;
		end else if (cmd.capture_cell) begin
			cell_q <= rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cell_value_q     <= cell_q;
			cursor_row_now_q <= ROW_SEL_W'(cur_row_q);
			cursor_col_now_q <= COL_SEL_W'(cur_col_q);
		end
	end

	assign cell_value     = cell_value_q;
	assign cursor_row_now = cursor_row_now_q;
	assign cursor_col_now = cursor_col_now_q;

	a_cursor_on_text_row: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cur_row_q) < ROWS - 1) && (32'(cur_col_q) < COLUMNS))
		else $error("cursor left the text area");

	a_copy_in_scroll_area: assert property (@(posedge clk) disable iff (!arst_n)
		(we_s1 && wcopy_s1) |-> (waddr_s1 <= COPY_LAST))
		else $error("scroll copy wrote outside the moved rows");

endmodule

`default_nettype wire
